/* rtl/url_percent_decoder_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the URL percent decoder
// Concurrent checks, compiled out when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef URL_PERCENT_DECODER_MACROS_SVH
`define URL_PERCENT_DECODER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled during reset
`define UPD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled during reset
`define UPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define UPD_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define UPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/upd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// upd_pkg
// Types, character codes and helpers shared by the URL percent decoder.
// ---------------------------------------------------------------------------
package upd_pkg;

    // result slots per input byte and the width of a slot count
    localparam int MAX_RES = 3;
    localparam int CNT_W   = 2;

    // character codes
    localparam logic [7:0] ESC_MARK   = 8'h25;  // '%'
    localparam logic [7:0] PLUS_MARK  = 8'h2B;  // '+'
    localparam logic [7:0] SPACE_CHAR = 8'h20;  // ' '

    // escape tracking state
    typedef enum logic [1:0] {
        ESC_IDLE  = 2'd0,   // nothing held
        ESC_PCT   = 2'd1,   // percent sign held
        ESC_DIGIT = 2'd2    // percent sign and one hex digit held
    } t_esc_phase;

    // decoded bytes of one transaction, slot 0 goes out first
    typedef struct packed {
        logic [CNT_W-1:0]           count;
        logic [MAX_RES-1:0][7:0]    bytes;
        logic [MAX_RES-1:0]         lasts;
    } t_res_set;

    // full decoder answer: results plus next escape state
    typedef struct packed {
        t_res_set   set;
        t_esc_phase phase;
        logic [7:0] held;
    } t_dec_res;

    // strict hex test: {is_digit, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* rtl/upd_dec.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// upd_dec
// Combinational decode of one byte against the held escape state.
// ---------------------------------------------------------------------------
module upd_dec (
    input  wire logic [7:0]          i_byte,
    input  wire logic                i_last,
    input  wire upd_pkg::t_esc_phase i_phase,
    input  wire logic [7:0]          i_held,
    output upd_pkg::t_dec_res        o_res
);

    logic [4:0]                      hb;
    logic [4:0]                      hh;
    logic [upd_pkg::CNT_W-1:0]       pre_n;
    logic                            run_fresh;
    logic                            is_esc;
    logic                            fr_emit;
    logic [7:0]                      fr_byte;
    upd_pkg::t_dec_res               res;

    always_comb begin
        hb        = upd_pkg::hex_digit(i_byte);
        hh        = upd_pkg::hex_digit(i_held);
        pre_n     = '0;
        run_fresh = 1'b1;
        res       = '0;
        res.phase = upd_pkg::ESC_IDLE;
        res.held  = i_held;

        // escape handling; a failed escape leaves a literal prefix
        unique case (i_phase)
            upd_pkg::ESC_PCT: begin
                if (hb[4]) begin
                    run_fresh = 1'b0;
                    if (i_last) begin
                        // string ends after one digit: flush both literally
                        res.set.count    = upd_pkg::CNT_W'(2);
                        res.set.bytes[0] = upd_pkg::ESC_MARK;
                        res.set.bytes[1] = i_byte;
                        res.set.lasts[1] = 1'b1;
                    end else begin
                        res.phase = upd_pkg::ESC_DIGIT;
                        res.held  = i_byte;
                    end
                end else begin
                    pre_n = upd_pkg::CNT_W'(1);
                end
            end
            upd_pkg::ESC_DIGIT: begin
                if (hb[4] && hh[4]) begin
                    run_fresh        = 1'b0;
                    res.set.count    = upd_pkg::CNT_W'(1);
                    res.set.bytes[0] = {hh[3:0], hb[3:0]};
                    res.set.lasts[0] = i_last;
                end else begin
                    pre_n = upd_pkg::CNT_W'(2);
                end
            end
            default: begin
            end
        endcase

        // plain decode of the byte, after any literal prefix
        is_esc  = (i_byte == upd_pkg::ESC_MARK);
        fr_emit = !(is_esc && !i_last);
        fr_byte = (i_byte == upd_pkg::PLUS_MARK) ? upd_pkg::SPACE_CHAR : i_byte;
        if (run_fresh) begin
            res.phase            = (is_esc && !i_last) ? upd_pkg::ESC_PCT : upd_pkg::ESC_IDLE;
            res.set.bytes[0]     = upd_pkg::ESC_MARK;
            res.set.bytes[1]     = i_held;
            res.set.bytes[pre_n] = fr_byte;
            res.set.lasts[pre_n] = i_last && fr_emit;
            res.set.count        = pre_n + upd_pkg::CNT_W'(fr_emit);
        end
    end

    assign o_res = res;

endmodule
`default_nettype wire

/* rtl/upd_oq.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// upd_oq
// Three-slot output queue; loads a whole result set, drains one per cycle while i_ready is high.
// ---------------------------------------------------------------------------
module upd_oq (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire upd_pkg::t_res_set i_set,
    input  wire logic              i_ready,
    output logic                   o_valid,
    output logic [7:0]             o_byte,
    output logic                   o_last,
    output logic                   o_drains
);

    logic [upd_pkg::CNT_W-1:0]          r_cnt;
    logic [upd_pkg::CNT_W-1:0]          n_cnt;
    logic [upd_pkg::MAX_RES-1:0][7:0]   r_byte;
    logic [upd_pkg::MAX_RES-1:0][7:0]   n_byte;
    logic [upd_pkg::MAX_RES-1:0]        r_last;
    logic [upd_pkg::MAX_RES-1:0]        n_last;
    logic                               pop;

    assign o_valid  = (r_cnt != '0);
    assign o_byte   = r_byte[0];
    assign o_last   = r_last[0];
    assign pop      = o_valid && i_ready;
    // empty after this edge, so a new set may be loaded
    assign o_drains = (r_cnt == '0) || ((r_cnt == upd_pkg::CNT_W'(1)) && pop);

    // load overrides shift; a load only happens when the queue drains
    always_comb begin
        n_cnt  = r_cnt;
        n_byte = r_byte;
        n_last = r_last;
        if (i_load) begin
            n_cnt  = i_set.count;
            n_byte = i_set.bytes;
            n_last = i_set.lasts;
        end else if (pop) begin
            n_cnt  = r_cnt - upd_pkg::CNT_W'(1);
            n_byte = {8'h00, r_byte[2], r_byte[1]};
            n_last = {1'b0, r_last[2], r_last[1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_last <= n_last;
    end

endmodule
`default_nettype wire

/* rtl/url_percent_decoder.sv */
// An accepted input transaction passes the input register, then the output queue.
// Throughput: one input byte per cycle while each byte yields at most one
// result and the output is ready; a byte yielding more results holds the input
// back until the three-slot output queue, drained one byte per cycle, empties.
// Reset: synchronous, active low; clears valids, queue count and escape state.
`timescale 1ns / 1ps
`default_nettype none
`include "url_percent_decoder_macros.svh"
// ---------------------------------------------------------------------------
// url_percent_decoder
// Streaming form-urlencoded decoder: %XX to a byte, '+' to space.
// ---------------------------------------------------------------------------
module url_percent_decoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_in_byte,
    input  wire logic        i_in_last,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [7:0]       o_out_byte,
    output logic             o_out_last
);

    logic                   r_in_valid;
    logic [7:0]             r_in_byte;
    logic                   r_in_last;
    upd_pkg::t_esc_phase    r_phase;
    upd_pkg::t_esc_phase    n_phase;
    logic [7:0]             r_held;
    logic [7:0]             n_held;
    upd_pkg::t_dec_res      dec;
    logic                   drains;
    logic                   move;

    // input register moves on once the queue empties
    assign move       = r_in_valid && drains;
    assign o_in_ready = !r_in_valid || move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_in_byte;
            r_in_last <= i_in_last;
        end
    end

    // decode against the escape state
    upd_dec u_dec (
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .i_phase (r_phase),
        .i_held  (r_held),
        .o_res   (dec)
    );

    // escape state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= upd_pkg::ESC_IDLE;
            r_held  <= 8'h00;
        end else begin
            r_phase <= n_phase;
            r_held  <= n_held;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_held  = r_held;
        if (move) begin
            n_phase = dec.phase;
            n_held  = dec.held;
        end
    end

    // result queue
    upd_oq u_oq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (move),
        .i_set    (dec.set),
        .i_ready  (i_out_ready),
        .o_valid  (o_out_valid),
        .o_byte   (o_out_byte),
        .o_last   (o_out_last),
        .o_drains (drains)
    );

    // checks
    `UPD_ASSERT_NEXT(a_load_shows, i_clk, i_rst_n, move, o_out_valid == ($past(dec.set.count) != 2'd0))
    `UPD_ASSERT_NEXT(a_last_ends_esc, i_clk, i_rst_n, move && r_in_last, r_phase == upd_pkg::ESC_IDLE)
    `UPD_ASSERT_NOW(a_move_when_empty, i_clk, i_rst_n, move && o_out_valid, i_out_ready)

endmodule
`default_nettype wire

/* tb/decoded_stream_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// decoded_stream_checker
// Watches both channels of the URL percent decoder. Every input transaction
// is run through a local form-urlencoded decoder, and the bytes it yields
// are queued. Every output transaction is compared with the oldest queued
// byte. Mismatches and unexpected bytes are counted.
// ---------------------------------------------------------------------------
module decoded_stream_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire logic [7:0]  i_in_byte,
    input  wire logic        i_in_last,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [7:0]  i_out_byte,
    input  wire logic        i_out_last,
    output int               o_fail_count,
    output int               o_pending
);

    // one decoded output byte
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_out_beat;

    t_out_beat           decoded_q[$];
    upd_pkg::t_esc_phase esc_state  = upd_pkg::ESC_IDLE;
    logic [7:0]          held_char  = 8'h00;
    int                  fail_cnt   = 0;

    // strict hex digit test: 0-9, A-F, a-f
    function automatic logic is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
               (c >= 8'h61 && c <= 8'h66);
    endfunction

    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        logic [7:0] v;
        if (c <= 8'h39) begin
            v = c - 8'h30;
        end else if (c >= 8'h61) begin
            v = c - 8'h57;
        end else begin
            v = c - 8'h37;
        end
        return v[3:0];
    endfunction

    task automatic queue_byte(input logic [7:0] d, input logic l);
        t_out_beat beat;
        beat.data = d;
        beat.last = l;
        decoded_q.push_back(beat);
    endtask

    // byte seen with no escape pending
    task automatic decode_plain(input logic [7:0] b, input logic l);
        if (b == upd_pkg::ESC_MARK) begin
            if (l) begin
                esc_state = upd_pkg::ESC_IDLE;
                queue_byte(upd_pkg::ESC_MARK, 1'b1);
            end else begin
                esc_state = upd_pkg::ESC_PCT;
            end
        end else begin
            esc_state = upd_pkg::ESC_IDLE;
            queue_byte((b == upd_pkg::PLUS_MARK) ? upd_pkg::SPACE_CHAR : b, l);
        end
    endtask

    // advance the escape state by one input byte
    task automatic predict_decode(input logic [7:0] b, input logic l);
        case (esc_state)
            upd_pkg::ESC_PCT: begin
                if (is_hex(b)) begin
                    if (l) begin
                        esc_state = upd_pkg::ESC_IDLE;
                        queue_byte(upd_pkg::ESC_MARK, 1'b0);
                        queue_byte(b, 1'b1);
                    end else begin
                        held_char = b;
                        esc_state = upd_pkg::ESC_DIGIT;
                    end
                end else begin
                    // lone percent: emit it, then treat b as fresh input
                    queue_byte(upd_pkg::ESC_MARK, 1'b0);
                    decode_plain(b, l);
                end
            end
            upd_pkg::ESC_DIGIT: begin
                if (is_hex(held_char) && is_hex(b)) begin
                    esc_state = upd_pkg::ESC_IDLE;
                    queue_byte({nibble_of(held_char), nibble_of(b)}, l);
                end else begin
                    queue_byte(upd_pkg::ESC_MARK, 1'b0);
                    queue_byte(held_char, 1'b0);
                    decode_plain(b, l);
                end
            end
            default: begin
                decode_plain(b, l);
            end
        endcase
    endtask

    // compare outputs first, then predict from the input transaction
    always @(posedge i_clk) begin : monitor
        t_out_beat want;
        if (!i_rst_n) begin
            esc_state = upd_pkg::ESC_IDLE;
            held_char = 8'h00;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (decoded_q.size() == 0) begin
                    $display("%0t: unexpected output byte 8'h%02h last %0b", $time,
                             i_out_byte, i_out_last);
                    fail_cnt++;
                end else begin
                    want = decoded_q.pop_front();
                    if (i_out_byte !== want.data) begin
                        $display("%0t: out_byte expected 8'h%02h actual 8'h%02h", $time,
                                 want.data, i_out_byte);
                        fail_cnt++;
                    end
                    if (i_out_last !== want.last) begin
                        $display("%0t: out_last expected %0b actual %0b", $time,
                                 want.last, i_out_last);
                        fail_cnt++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_decode(i_in_byte, i_in_last);
            end
        end
        o_fail_count <= fail_cnt;
        o_pending    <= decoded_q.size();
    end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Drives encoded strings into the URL percent decoder: a short directed set
// of escapes, plus signs and broken escapes, then random strings built
// mostly from valid escapes. Both sides idle at random, the output side
// holds off once long enough to back up the input. Checking is done by
// decoded_stream_checker.
// ---------------------------------------------------------------------------
module testbench;

    localparam int CLK_HALF    = 5;
    localparam int RST_CYCLES  = 6;
    localparam int HOLD_CYCLES = 48;
    localparam int CYCLE_LIMIT = 60000;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] in_byte;
    logic       in_last;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] out_byte;
    logic       out_last;

    int   fail_count;
    int   pending;
    int   cycle_cnt;
    int   sent_cnt = 0;
    int   hold_cnt = 0;
    logic idle_on  = 1'b0;

    always #CLK_HALF clk = ~clk;

    url_percent_decoder DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_byte   (in_byte),
        .i_in_last   (in_last),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_byte  (out_byte),
        .o_out_last  (out_last)
    );

    decoded_stream_checker u_chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_byte    (in_byte),
        .i_in_last    (in_last),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_byte   (out_byte),
        .i_out_last   (out_last),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // offer one byte at the falling edge, hold it until the transaction
    task automatic put_byte(input logic [7:0] b, input logic l);
        in_valid <= 1'b1;
        in_byte  <= b;
        in_last  <= l;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sent_cnt++;
        @(negedge clk);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            put_byte(s[i], i == s.len() - 1);
        end
    endtask

    function automatic logic [7:0] hex_char();
        int k;
        k = $urandom_range(0, 21);
        if (k < 10) return 8'(8'h30 + k);
        if (k < 16) return 8'(8'h41 + k - 10);
        return 8'(8'h61 + k - 16);
    endfunction

    // random string: mostly valid escapes, some plus signs, cut escapes, noise
    task automatic put_random_string();
        logic [7:0] chars[$];
        int n;
        int k;
        n = $urandom_range(1, 6);
        repeat (n) begin
            k = $urandom_range(0, 99);
            if (k < 40) begin
                chars.push_back(upd_pkg::ESC_MARK);
                chars.push_back(hex_char());
                chars.push_back(hex_char());
            end else if (k < 50) begin
                chars.push_back(upd_pkg::PLUS_MARK);
            end else if (k < 58) begin
                chars.push_back(upd_pkg::ESC_MARK);
                chars.push_back(hex_char());
            end else if (k < 63) begin
                chars.push_back(upd_pkg::ESC_MARK);
            end else begin
                chars.push_back(8'($urandom_range(0, 255)));
            end
        end
        foreach (chars[i]) begin
            put_byte(chars[i], i == chars.size() - 1);
        end
    endtask

    task automatic run_random(input int count);
        int target;
        target = sent_cnt + count;
        while (sent_cnt < target) put_random_string();
    endtask

    // drop valid and wait for every queued result
    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
    endtask

    // output side: long hold-off on request, else random stall bursts
    initial begin : receiver
        int hold_seen;
        hold_seen = 0;
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_cnt != hold_seen) begin
                hold_seen = hold_cnt;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                out_ready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(negedge clk);
                out_ready <= 1'b1;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // watchdog
    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("testbench NOT OK");
        $finish;
    end

    // stimulus and verdict
    initial begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_byte  = 8'h00;
        in_last  = 1'b0;
        repeat (RST_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: plus, both hex cases, percent at end, escape cut after
        // one digit, percent restarting an escape, bad third byte, zero byte
        put_text("a+%4a%7E");
        put_text("%");
        put_text("%4");
        put_text("%%41");
        put_text("%4+");
        put_text("%00");
        put_byte(8'h00, 1'b0);
        put_byte(8'hFF, 1'b1);

        idle_on <= 1'b1;
        run_random(70);

        // output held off while input keeps coming
        hold_cnt <= hold_cnt + 1;
        run_random(25);
        drain();

        run_random(70);

        // closing stretch at full rate
        idle_on <= 1'b0;
        run_random(35);
        drain();
        repeat (8) @(negedge clk);

        if (fail_count == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
